[rtl/one_wire_bus_master_macros.svh]
// Assertion macros for the one-wire bus master.
// Used at the end of the top level; clk and rst_n are taken from the scope of the use.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH
`ifndef ASSERT_OFF
`define OWB_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define OWB_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define OWB_ASSERT_IMP(lbl, cond, prop)
`define OWB_ASSERT_NXT(lbl, cond, prop)
`endif
`endif

[rtl/owb_pkg.sv]
// Shared types and constants for the one-wire bus master.
// No dependencies; imported by every module of the block.
package owb_pkg;

    localparam int COUNT_BITS = 10;
    localparam int BYTE_BITS  = 8;
    localparam int BIT_IDX_W  = $clog2(BYTE_BITS);
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);

    // operation codes
    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_RST_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRES_WAIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RST_REC   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WR_LOW    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WR_HOLD   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RD_LOW    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RD_SAMPLE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RD_REC    = 3'd7;

    // register defaults
    localparam logic [COUNT_BITS-1:0] DEF_RST_LOW   = 10'd500;
    localparam logic [COUNT_BITS-1:0] DEF_PRES_WAIT = 10'd70;
    localparam logic [COUNT_BITS-1:0] DEF_RST_REC   = 10'd500;
    localparam logic [COUNT_BITS-1:0] DEF_WR_LOW    = 10'd10;
    localparam logic [COUNT_BITS-1:0] DEF_WR_HOLD   = 10'd50;
    localparam logic [COUNT_BITS-1:0] DEF_RD_LOW    = 10'd9;
    localparam logic [COUNT_BITS-1:0] DEF_RD_SAMPLE = 10'd9;
    localparam logic [COUNT_BITS-1:0] DEF_RD_REC    = 10'd50;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_WR_LOW,
        PH_WR_HOLD,
        PH_WR_REL,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_REC
    } phase_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] rst_low;
        logic [COUNT_BITS-1:0] pres_wait;
        logic [COUNT_BITS-1:0] rst_rec;
        logic [COUNT_BITS-1:0] wr_low;
        logic [COUNT_BITS-1:0] wr_hold;
        logic [COUNT_BITS-1:0] rd_low;
        logic [COUNT_BITS-1:0] rd_sample;
        logic [COUNT_BITS-1:0] rd_rec;
    } cfg_t;

    typedef struct packed {
        logic                 drive_low;
        logic                 busy;
        logic                 done;
        logic                 presence;
        logic [BYTE_BITS-1:0] rx_byte;
    } result_t;

endpackage

[rtl/owb_cfg.sv]
// Timing register file of the one-wire bus master.
// Depends on owb_pkg.
module owb_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [owb_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [owb_pkg::COUNT_BITS-1:0] cfg_data,
    output owb_pkg::cfg_t                  cfg
);
    import owb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RST_LOW:   cfg_next.rst_low   = cfg_data;
                REG_PRES_WAIT: cfg_next.pres_wait = cfg_data;
                REG_RST_REC:   cfg_next.rst_rec   = cfg_data;
                REG_WR_LOW:    cfg_next.wr_low    = cfg_data;
                REG_WR_HOLD:   cfg_next.wr_hold   = cfg_data;
                REG_RD_LOW:    cfg_next.rd_low    = cfg_data;
                REG_RD_SAMPLE: cfg_next.rd_sample = cfg_data;
                REG_RD_REC:    cfg_next.rd_rec    = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rst_low   <= DEF_RST_LOW;
            cfg_reg.pres_wait <= DEF_PRES_WAIT;
            cfg_reg.rst_rec   <= DEF_RST_REC;
            cfg_reg.wr_low    <= DEF_WR_LOW;
            cfg_reg.wr_hold   <= DEF_WR_HOLD;
            cfg_reg.rd_low    <= DEF_RD_LOW;
            cfg_reg.rd_sample <= DEF_RD_SAMPLE;
            cfg_reg.rd_rec    <= DEF_RD_REC;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/owb_seq.sv]
// Slot sequencer of the one-wire bus master: phase, tick counter, bit index, shifter.
// Depends on owb_pkg; advances one tick per accepted item.
module owb_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          start_req,
    input  logic [1:0]                    operation,
    input  logic [owb_pkg::BYTE_BITS-1:0] tx_byte,
    input  logic                          line_level,
    input  owb_pkg::cfg_t                 cfg,
    output owb_pkg::result_t              result
);
    import owb_pkg::*;

    phase_t                phase_reg,    phase_next;
    logic [COUNT_BITS-1:0] cnt_reg,      cnt_next;
    logic [BIT_IDX_W-1:0]  bit_reg,      bit_next;
    logic [BYTE_BITS-1:0]  shift_reg,    shift_next;
    logic                  presence_reg, presence_next;
    logic [BYTE_BITS-1:0]  rx_reg,       rx_next;

    logic [COUNT_BITS-1:0] len_raw;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  expire;
    logic                  last_bit;
    logic                  done;

    // phase length; a zero register counts as one tick
    always_comb
    begin
        unique case (phase_reg)
            PH_RST_LOW:  len_raw = cfg.rst_low;
            PH_RST_WAIT: len_raw = cfg.pres_wait;
            PH_RST_REC:  len_raw = cfg.rst_rec;
            PH_WR_LOW:   len_raw = cfg.wr_low;
            PH_WR_HOLD:  len_raw = cfg.wr_hold;
            PH_RD_LOW:   len_raw = cfg.rd_low;
            PH_RD_WAIT:  len_raw = cfg.rd_sample;
            PH_RD_REC:   len_raw = cfg.rd_rec;
            default:     len_raw = COUNT_BITS'(1);
        endcase
    end

    assign cnt_inc  = cnt_reg + COUNT_BITS'(1);
    assign expire   = (cnt_inc >= len_raw) || (cnt_inc == '0);
    assign last_bit = (bit_reg == BIT_IDX_W'(BYTE_BITS - 1));

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        rx_next       = rx_reg;
        done          = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (start_req)
            begin
                unique case (operation)
                    OP_RESET:
                    begin
                        phase_next = PH_RST_LOW;
                        cnt_next   = '0;
                        bit_next   = '0;
                    end
                    OP_WRITE:
                    begin
                        phase_next = PH_WR_LOW;
                        cnt_next   = '0;
                        bit_next   = '0;
                        shift_next = tx_byte;
                    end
                    OP_READ:
                    begin
                        phase_next = PH_RD_LOW;
                        cnt_next   = '0;
                        bit_next   = '0;
                        shift_next = '0;
                    end
                    default:
                    begin
                        // undefined code: stay idle
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else if (!expire)
        begin
            cnt_next = cnt_inc;
        end
        else
        begin
            cnt_next = '0;
            unique case (phase_reg)
                PH_RST_LOW:  phase_next = PH_RST_WAIT;
                PH_RST_WAIT:
                begin
                    presence_next = line_level;
                    phase_next    = PH_RST_REC;
                end
                PH_RST_REC:
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                PH_WR_LOW:   phase_next = PH_WR_HOLD;
                PH_WR_HOLD:
                begin
                    done       = last_bit;
                    phase_next = last_bit ? PH_IDLE : PH_WR_REL;
                end
                PH_WR_REL:
                begin
                    bit_next   = bit_reg + BIT_IDX_W'(1);
                    phase_next = PH_WR_LOW;
                end
                PH_RD_LOW:   phase_next = PH_RD_WAIT;
                PH_RD_WAIT:
                begin
                    if (line_level)
                    begin
                        shift_next[bit_reg] = 1'b1;
                    end
                    phase_next = PH_RD_REC;
                end
                PH_RD_REC:
                begin
                    if (last_bit)
                    begin
                        rx_next    = shift_reg;
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        bit_next   = bit_reg + BIT_IDX_W'(1);
                        phase_next = PH_RD_LOW;
                    end
                end
                default:     phase_next = PH_IDLE;
            endcase
        end
    end

    // result for this tick, taken from the updated state
    always_comb
    begin
        unique case (phase_next)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: result.drive_low = 1'b1;
            PH_WR_HOLD:                       result.drive_low = ~shift_next[bit_next];
            default:                          result.drive_low = 1'b0;
        endcase
        result.busy     = (phase_next != PH_IDLE);
        result.done     = done;
        result.presence = presence_next;
        result.rx_byte  = rx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cnt_reg      <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b1;
            rx_reg       <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            rx_reg       <= rx_next;
        end
    end

endmodule

[rtl/one_wire_bus_master.sv]
// One-wire bus master top level. A result appears in the output register in the cycle
// after its tick is transferred in.
// Throughput: one tick per cycle; the output register frees in the same cycle it is
// taken, so the input stalls only while a finished result is held by out_stall.
// Reset (rst_n, asynchronous, active low): idle, presence 1, read byte 0, timing
// registers at their defaults.
`include "one_wire_bus_master_macros.svh"
module one_wire_bus_master (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [owb_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [owb_pkg::COUNT_BITS-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           start_req,
    input  logic [1:0]                     operation,
    input  logic [owb_pkg::BYTE_BITS-1:0]  tx_byte,
    input  logic                           line_level,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           drive_low,
    output logic                           busy_res,
    output logic                           done_res,
    output logic                           presence_level,
    output logic [owb_pkg::BYTE_BITS-1:0]  rx_byte
);
    import owb_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg, out_valid_next;
    logic    in_xfer;

    owb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owb_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (in_xfer),
        .start_req  (start_req),
        .operation  (operation),
        .tx_byte    (tx_byte),
        .line_level (line_level),
        .cfg        (cfg),
        .result     (result)
    );

    // hold the input only while a result waits and the sink stalls
    assign in_stall       = out_valid_reg & out_stall;
    assign in_xfer        = in_valid & ~in_stall;
    assign out_valid_next = in_xfer | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_low      = result_reg.drive_low;
    assign busy_res       = result_reg.busy;
    assign done_res       = result_reg.done;
    assign presence_level = result_reg.presence;
    assign rx_byte        = result_reg.rx_byte;

    `OWB_ASSERT_NXT(a_xfer_gives_result, in_valid && !in_stall, out_valid)
    `OWB_ASSERT_NXT(a_drain_empties, out_valid && !out_stall && !in_valid, !out_valid)
    `OWB_ASSERT_IMP(a_done_not_busy, out_valid && done_res, !busy_res)
    `OWB_ASSERT_IMP(a_drive_only_busy, out_valid && drive_low, busy_res)

endmodule

[test/tb_top.sv]
// Self-checking testbench for the one-wire bus master: directed ticks, then random
// bus sequences, compared per field with table values or an in-bench model of the sequencer.
// Depends on owb_pkg and the one_wire_bus_master RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import owb_pkg::*;

    localparam logic [1:0] OP_UNDEF = 2'd3;
    localparam int HOLD_CYCLES = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [COUNT_BITS-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  start_req = 1'b0;
    logic [1:0]            operation = OP_RESET;
    logic [BYTE_BITS-1:0]  tx_byte = '0;
    logic                  line_level = 1'b1;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  drive_low;
    logic                  busy_res;
    logic                  done_res;
    logic                  presence_level;
    logic [BYTE_BITS-1:0]  rx_byte;

    one_wire_bus_master dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_req      (start_req),
        .operation      (operation),
        .tx_byte        (tx_byte),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .presence_level (presence_level),
        .rx_byte        (rx_byte)
    );

    always #6 clk = ~clk;

    // sequencer model state
    logic [COUNT_BITS-1:0] timing [NUM_REGS];
    phase_t                bus_phase;
    logic [COUNT_BITS-1:0] bus_count;
    logic [BIT_IDX_W-1:0]  bit_pos;
    logic [BYTE_BITS-1:0]  shift_reg;
    logic                  presence_q;
    logic [BYTE_BITS-1:0]  last_rx;

    result_t bus_results_due [$];
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    bit      want_hold = 1'b0;
    bit      hold_taken = 1'b0;
    int      hold_left = 0;

    typedef struct {
        logic                 start;
        logic [1:0]           op;
        logic [BYTE_BITS-1:0] tx;
        logic                 line;
        int                   reps;
        bit                   has_exp;
        result_t              exp_res;
    } tick_row_t;

    localparam int DIR_ROWS = 14;
    tick_row_t directed_ticks [DIR_ROWS] = '{
        '{1'b0, OP_RESET, 8'h00, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
        '{1'b1, OP_UNDEF, 8'hFF, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
        '{1'b1, OP_RESET, 8'h00, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
        '{1'b1, OP_WRITE, 8'hFF, 1'b0, 1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00}},
        '{1'b0, OP_RESET, 8'h00, 1'b0, 1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
        '{1'b0, OP_RESET, 8'h00, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}},
        '{1'b0, OP_READ,  8'h00, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
        '{1'b1, OP_RESET, 8'h00, 1'b1, 5, 1'b0, '0},
        '{1'b1, OP_WRITE, 8'hFF, 1'b1, 26, 1'b0, '0},
        '{1'b1, OP_WRITE, 8'h00, 1'b0, 26, 1'b0, '0},
        '{1'b1, OP_READ,  8'h00, 1'b1, 27, 1'b0, '0},
        '{1'b1, OP_READ,  8'hFF, 1'b0, 27, 1'b0, '0},
        '{1'b1, OP_WRITE, 8'h5A, 1'b1, 26, 1'b0, '0},
        '{1'b1, OP_READ,  8'hA5, 1'b1, 27, 1'b0, '0}
    };

    function automatic logic [COUNT_BITS-1:0] slot_len(phase_t p);
        logic [COUNT_BITS-1:0] v;
        case (p)
            PH_RST_LOW:  v = timing[REG_RST_LOW];
            PH_RST_WAIT: v = timing[REG_PRES_WAIT];
            PH_RST_REC:  v = timing[REG_RST_REC];
            PH_WR_LOW:   v = timing[REG_WR_LOW];
            PH_WR_HOLD:  v = timing[REG_WR_HOLD];
            PH_RD_LOW:   v = timing[REG_RD_LOW];
            PH_RD_WAIT:  v = timing[REG_RD_SAMPLE];
            PH_RD_REC:   v = timing[REG_RD_REC];
            default:     v = COUNT_BITS'(1);
        endcase
        return (v == '0) ? COUNT_BITS'(1) : v;
    endfunction

    task automatic predict_bus_tick(input logic start, input logic [1:0] op,
                                    input logic [BYTE_BITS-1:0] tx, input logic line,
                                    output result_t r);
        logic   fin;
        phase_t nxt;
        fin = 1'b0;
        if (bus_phase == PH_IDLE)
        begin
            if (start && op != OP_UNDEF)
            begin
                bus_count = '0;
                bit_pos = '0;
                if (op == OP_RESET)
                begin
                    bus_phase = PH_RST_LOW;
                end
                else if (op == OP_WRITE)
                begin
                    shift_reg = tx;
                    bus_phase = PH_WR_LOW;
                end
                else
                begin
                    shift_reg = '0;
                    bus_phase = PH_RD_LOW;
                end
            end
        end
        else
        begin
            bus_count = bus_count + 1'b1;
            if (bus_count >= slot_len(bus_phase) || bus_count == '0)
            begin
                nxt = PH_IDLE;
                bus_count = '0;
                case (bus_phase)
                    PH_RST_LOW:  nxt = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_q = line;
                        nxt = PH_RST_REC;
                    end
                    PH_RST_REC:  fin = 1'b1;
                    PH_WR_LOW:   nxt = PH_WR_HOLD;
                    PH_WR_HOLD:
                    begin
                        if (bit_pos == BYTE_BITS - 1)
                            fin = 1'b1;
                        else
                            nxt = PH_WR_REL;
                    end
                    PH_WR_REL:
                    begin
                        bit_pos = bit_pos + 1'b1;
                        nxt = PH_WR_LOW;
                    end
                    PH_RD_LOW:   nxt = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        if (line)
                            shift_reg[bit_pos] = 1'b1;
                        nxt = PH_RD_REC;
                    end
                    PH_RD_REC:
                    begin
                        if (bit_pos == BYTE_BITS - 1)
                        begin
                            last_rx = shift_reg;
                            fin = 1'b1;
                        end
                        else
                        begin
                            bit_pos = bit_pos + 1'b1;
                            nxt = PH_RD_LOW;
                        end
                    end
                    default: ;
                endcase
                bus_phase = nxt;
            end
        end
        case (bus_phase)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: r.drive_low = 1'b1;
            // a 0 bit keeps the line pulled low through the hold
            PH_WR_HOLD: r.drive_low = ~shift_reg[bit_pos];
            default:    r.drive_low = 1'b0;
        endcase
        r.busy = (bus_phase != PH_IDLE);
        r.done = fin;
        r.presence = presence_q;
        r.rx_byte = last_rx;
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("tb_top: mismatch on %s: got %0h, expected %0h at %0t",
                 what, got, want, $realtime);
    endtask

    // offer one tick, hold it until transferred, then record its expected result
    task automatic send_tick(input logic start, input logic [1:0] op,
                             input logic [BYTE_BITS-1:0] tx, input logic line,
                             input bit has_exp, input result_t exp_res);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        start_req <= start;
        operation <= op;
        tx_byte <= tx;
        line_level <= line;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_bus_tick(start, op, tx, line, r);
        bus_results_due.push_back(has_exp ? exp_res : r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (bus_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timing();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= REG_IDX_W'(i);
            cfg_data <= timing[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic begin_phase(input int send_pct, input int recv_pct,
                               input int lo, input int hi);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
        for (int i = 0; i < NUM_REGS; i++)
            timing[i] = COUNT_BITS'($urandom_range(hi, lo));
        write_timing();
    endtask

    // random ticks: mostly well-formed starts, with stray starts while busy
    task automatic run_traffic(input int ticks);
        int         roll;
        logic       s;
        logic [1:0] o;
        for (int n = 0; n < ticks; n++)
        begin
            o = 2'($urandom_range(3));
            if (bus_phase == PH_IDLE)
            begin
                roll = $urandom_range(99);
                s = (roll >= 12);
                if (roll >= 12 && roll < 17)
                    o = OP_UNDEF;
                else if (roll >= 17)
                    o = 2'($urandom_range(2));
            end
            else
            begin
                s = ($urandom_range(4) == 0);
            end
            send_tick(s, o, BYTE_BITS'($urandom), 1'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (want_hold && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bus_results_due.size() == 0)
            begin
                flag_mismatch("unexpected transfer", 1, 0);
            end
            else
            begin
                want = bus_results_due.pop_front();
                if (drive_low !== want.drive_low)
                    flag_mismatch("drive_low", int'(drive_low), int'(want.drive_low));
                if (busy_res !== want.busy)
                    flag_mismatch("busy_res", int'(busy_res), int'(want.busy));
                if (done_res !== want.done)
                    flag_mismatch("done_res", int'(done_res), int'(want.done));
                if (presence_level !== want.presence)
                    flag_mismatch("presence_level", int'(presence_level),
                                  int'(want.presence));
                if (rx_byte !== want.rx_byte)
                    flag_mismatch("rx_byte", int'(rx_byte), int'(want.rx_byte));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        timing = '{DEF_RST_LOW, DEF_PRES_WAIT, DEF_RST_REC, DEF_WR_LOW,
                   DEF_WR_HOLD, DEF_RD_LOW, DEF_RD_SAMPLE, DEF_RD_REC};
        bus_phase = PH_IDLE;
        bus_count = '0;
        bit_pos = '0;
        shift_reg = '0;
        presence_q = 1'b1;
        last_rx = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // shortest slots; a zero register must act as one tick
        for (int i = 0; i < NUM_REGS; i++)
            timing[i] = COUNT_BITS'(1);
        timing[REG_WR_LOW] = '0;
        timing[REG_RD_LOW] = '0;
        write_timing();

        foreach (directed_ticks[i])
            for (int k = 0; k < directed_ticks[i].reps; k++)
                send_tick(directed_ticks[i].start && k == 0, directed_ticks[i].op,
                          directed_ticks[i].tx, directed_ticks[i].line,
                          directed_ticks[i].has_exp, directed_ticks[i].exp_res);
        settle();

        begin_phase(0, 0, 0, 4);
        run_traffic(45);
        settle();
        begin_phase(45, 0, 1, 6);
        run_traffic(45);
        settle();
        begin_phase(0, 45, 0, 8);
        run_traffic(45);
        settle();
        begin_phase(6, 6, 1, 5);
        run_traffic(45);
        settle();

        // long receiver hold while ticks keep coming: the input must back up
        begin_phase(0, 0, 1, 3);
        want_hold = 1'b1;
        run_traffic(50);
        settle();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
